// ===== hw/rtl/ibmc_pkg.sv =====
`timescale 1ns / 1ps

package ibmc_pkg;

    localparam int WINDOW_DEFAULT = 8;
    localparam int MAG_W          = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;

    // item kinds
    localparam logic [1:0] KIND_SAMPLE  = 2'd0;
    localparam logic [1:0] KIND_COMMAND = 2'd1;
    localparam logic [1:0] KIND_TICK    = 2'd2;

    // app commands
    localparam logic [2:0] CMD_LEFT_ON   = 3'd0;
    localparam logic [2:0] CMD_LEFT_OFF  = 3'd1;
    localparam logic [2:0] CMD_RIGHT_ON  = 3'd2;
    localparam logic [2:0] CMD_RIGHT_OFF = 3'd3;
    localparam logic [2:0] CMD_FALSE_ALM = 3'd4;
    localparam logic [2:0] CMD_PARTY     = 3'd5;
    localparam logic [2:0] CMD_NORMAL    = 3'd6;

    // helmet states
    localparam logic [2:0] HS_NORMAL  = 3'd0;
    localparam logic [2:0] HS_BRAKING = 3'd1;
    localparam logic [2:0] HS_LEFT    = 3'd2;
    localparam logic [2:0] HS_RIGHT   = 3'd3;
    localparam logic [2:0] HS_CRASH   = 3'd4;
    localparam logic [2:0] HS_PARTY   = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CRASH_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE_THR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE_HOLD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CRASH_CONF = 2'd3;

    localparam logic [CFG_DATA_W-1:0] CRASH_THR_RST  = 16'd16384;
    localparam logic [CFG_DATA_W-1:0] BRAKE_THR_RST  = 16'd2048;
    localparam logic [CFG_DATA_W-1:0] BRAKE_HOLD_RST = 16'd2000;
    localparam logic [CFG_DATA_W-1:0] CRASH_CONF_RST = 16'd30000;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic [2:0]         command;
    } in_item_t;

    typedef struct packed {
        logic [2:0]       helmet_state;
        logic [MAG_W-1:0] magnitude;
        logic [MAG_W-1:0] average;
        logic             crash_event;
        logic             brake_seen;
        logic             crash_confirmed;
    } out_item_t;

endpackage

// ===== hw/rtl/impact_brake_mode_controller_core.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    in_item   (in_item_t)
// out       output     out_valid / out_ready  out_item  (out_item_t)
// cfg       input      cfg_we                 cfg_index, cfg_data
//
// A sample is squared and summed over its three axes on one multiplier, then takes 16
// root steps on one subtractor, the window update, one reciprocal multiply for the
// average from the sample that fills the window on, the result load and a return to idle.
// Commands, ticks and unknown kinds go from accept straight to the result load.
// rst_n clears mode, timers and window bookkeeping and loads the threshold defaults;
// the window store is not cleared. in_ready is low from accept until the result is
// loaded into the output register, and the result waits there while out_ready is low.

module impact_brake_mode_controller_core
    import ibmc_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_item,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PTR_W  = $clog2(WINDOW);
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = MAG_W + PTR_W;
    localparam int CNT_W  = 4;

    // floor(sum / WINDOW) as (sum * ceil(2^DIV_SHIFT / WINDOW)) >> DIV_SHIFT,
    // exact for every SUM_W-bit sum
    localparam int DIV_SHIFT = SUM_W + PTR_W;
    localparam int RECIP_W   = SUM_W + 1;
    localparam int PROD_W    = 2 * SUM_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(WINDOW - 1)) / 64'(WINDOW));

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SQRT,
        S_WIN,
        S_DIV,
        S_UPDATE
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    in_item_t              item_reg, item_next;
    logic [31:0]           prod_reg, prod_next;
    logic [31:0]           rem_reg, rem_next;
    logic [31:0]           root_reg, root_next;
    logic [MAG_W-1:0]      mag_reg, mag_next;
    logic [MAG_W-1:0]      avg_reg, avg_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic [PTR_W-1:0]      ptr_reg, ptr_next;
    logic [2:0]            mode_reg, mode_next;
    logic [15:0]           brake_el_reg, brake_el_next;
    logic [15:0]           crash_el_reg, crash_el_next;
    logic [CFG_DATA_W-1:0] crash_thr_reg, crash_thr_next;
    logic [CFG_DATA_W-1:0] brake_thr_reg, brake_thr_next;
    logic [CFG_DATA_W-1:0] brake_hold_reg, brake_hold_next;
    logic [CFG_DATA_W-1:0] crash_conf_reg, crash_conf_next;
    logic                  out_valid_reg, out_valid_next;
    out_item_t             out_item_reg, out_item_next;

    // window store
    logic [MAG_W-1:0]      win_mem [WINDOW];
    logic [MAG_W-1:0]      old_mag_reg;
    logic                  mem_we;

    // compare / subtract for the root steps
    logic [31:0]           sub_a, sub_b;
    logic [32:0]           sub_diff;
    logic                  sub_ge;
    logic [31:0]           sqrt_bit;

    logic signed [15:0]    sq_op;
    logic signed [31:0]    sq_prod;

    logic                  win_full;
    logic [SUM_W-1:0]      win_sum;
    logic [PROD_W-1:0]     div_prod;

    // result of the item-specific update
    logic                  upd_crash, upd_brake, upd_empty;
    logic                  upd_crash_ev, upd_conf;
    logic [17:0]           ax_sum;
    logic [2:0]            mode_a, mode_f;
    logic [15:0]           brake_el_a, crash_el_a;
    logic                  is_sample;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign sqrt_bit = 32'd1 << {cnt_reg[3:0], 1'b0};

    always_comb
    begin
        sub_a = '0;
        sub_b = '0;
        case (state_reg)
            S_SQRT:
            begin
                sub_a = rem_reg;
                sub_b = root_reg + sqrt_bit;
            end
            default: ;
        endcase
    end

    assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge   = ~sub_diff[32];

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    sq_op = item_reg.accel_x;
            2'd1:    sq_op = item_reg.accel_y;
            default: sq_op = item_reg.accel_z;
        endcase
    end

    assign sq_prod = sq_op * sq_op;

    assign win_full = (fill_reg == FILL_W'(WINDOW));
    assign win_sum  = win_full ? sum_reg - SUM_W'(old_mag_reg) + SUM_W'(root_reg[15:0])
                               : sum_reg + SUM_W'(root_reg[15:0]);

    assign div_prod = PROD_W'(root_reg[SUM_W-1:0]) * PROD_W'(RECIP);

    // mode update for the item held in item_reg
    assign is_sample = (item_reg.mode == KIND_SAMPLE);
    assign upd_crash = (mag_reg > crash_thr_reg);
    // forward axis below -brake_threshold
    assign ax_sum    = {{2{item_reg.accel_x[15]}}, item_reg.accel_x} + {2'b00, brake_thr_reg};
    assign upd_brake = is_sample && !upd_crash && (avg_reg > brake_thr_reg)
                       && (avg_reg < crash_thr_reg) && ax_sum[17];

    always_comb
    begin
        mode_a       = mode_reg;
        brake_el_a   = brake_el_reg;
        crash_el_a   = crash_el_reg;
        upd_crash_ev = 1'b0;
        upd_empty    = 1'b0;
        case (item_reg.mode)
            KIND_SAMPLE:
            begin
                if (upd_crash && mode_reg != HS_CRASH)
                begin
                    mode_a       = HS_CRASH;
                    crash_el_a   = '0;
                    upd_crash_ev = 1'b1;
                    upd_empty    = 1'b1;
                end
                if (upd_brake && mode_a != HS_CRASH && mode_a != HS_LEFT
                    && mode_a != HS_RIGHT && mode_a != HS_BRAKING)
                begin
                    mode_a     = HS_BRAKING;
                    brake_el_a = '0;
                end
            end
            KIND_COMMAND:
            begin
                case (item_reg.command)
                    CMD_LEFT_ON:   if (mode_reg != HS_CRASH) mode_a = HS_LEFT;
                    CMD_LEFT_OFF:  if (mode_reg == HS_LEFT) mode_a = HS_NORMAL;
                    CMD_RIGHT_ON:  if (mode_reg != HS_CRASH) mode_a = HS_RIGHT;
                    CMD_RIGHT_OFF: if (mode_reg == HS_RIGHT) mode_a = HS_NORMAL;
                    CMD_FALSE_ALM: if (mode_reg == HS_CRASH) mode_a = HS_NORMAL;
                    CMD_PARTY:     if (mode_reg != HS_CRASH) mode_a = HS_PARTY;
                    CMD_NORMAL:    if (mode_reg != HS_CRASH) mode_a = HS_NORMAL;
                    default: ;
                endcase
            end
            KIND_TICK:
            begin
                if (mode_reg == HS_BRAKING && brake_el_reg != 16'hFFFF)
                    brake_el_a = brake_el_reg + 16'd1;
                if (mode_reg == HS_CRASH && crash_el_reg != 16'hFFFF)
                    crash_el_a = crash_el_reg + 16'd1;
            end
            default: ;
        endcase
        mode_f = mode_a;
        if (mode_a == HS_BRAKING && brake_el_a >= brake_hold_reg)
            mode_f = HS_NORMAL;
        upd_conf = (mode_f == HS_CRASH) && (crash_el_a >= crash_conf_reg);
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        item_next       = item_reg;
        prod_next       = prod_reg;
        rem_next        = rem_reg;
        root_next       = root_reg;
        mag_next        = mag_reg;
        avg_next        = avg_reg;
        sum_next        = sum_reg;
        fill_next       = fill_reg;
        ptr_next        = ptr_reg;
        mode_next       = mode_reg;
        brake_el_next   = brake_el_reg;
        crash_el_next   = crash_el_reg;
        crash_thr_next  = crash_thr_reg;
        brake_thr_next  = brake_thr_reg;
        brake_hold_next = brake_hold_reg;
        crash_conf_next = crash_conf_reg;
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        mem_we          = 1'b0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CRASH_THR:  crash_thr_next  = cfg_data;
                REG_BRAKE_THR:  brake_thr_next  = cfg_data;
                REG_BRAKE_HOLD: brake_hold_next = cfg_data;
                REG_CRASH_CONF: crash_conf_next = cfg_data;
                default: ;
            endcase
        end

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next = in_item;
                    cnt_next  = '0;
                    rem_next  = '0;
                    state_next = (in_item.mode == KIND_SAMPLE) ? S_MUL : S_UPDATE;
                end
            end
            S_MUL:
            begin
                // square one axis per cycle, accumulate the previous square
                prod_next = 32'(sq_prod);
                if (cnt_reg != '0)
                    rem_next = rem_reg + prod_reg;
                if (cnt_reg == CNT_W'(3))
                begin
                    cnt_next   = CNT_W'(15);
                    root_next  = '0;
                    state_next = S_SQRT;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_SQRT:
            begin
                if (sub_ge)
                begin
                    rem_next  = sub_diff[31:0];
                    root_next = (root_reg >> 1) + sqrt_bit;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                if (cnt_reg == '0)
                    state_next = S_WIN;
                else
                    cnt_next = cnt_reg - CNT_W'(1);
            end
            S_WIN:
            begin
                mag_next = root_reg[15:0];
                mem_we   = 1'b1;
                sum_next = win_sum;
                if (!win_full)
                    fill_next = fill_reg + FILL_W'(1);
                ptr_next = (ptr_reg == PTR_W'(WINDOW - 1)) ? '0 : ptr_reg + PTR_W'(1);
                if (win_full || fill_reg == FILL_W'(WINDOW - 1))
                begin
                    // window sum goes to the reciprocal multiply next cycle
                    root_next  = 32'(win_sum);
                    state_next = S_DIV;
                end
                else
                begin
                    avg_next   = root_reg[15:0];
                    state_next = S_UPDATE;
                end
            end
            S_DIV:
            begin
                avg_next   = div_prod[DIV_SHIFT +: MAG_W];
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    mode_next     = mode_f;
                    brake_el_next = brake_el_a;
                    crash_el_next = crash_el_a;
                    if (upd_empty)
                    begin
                        sum_next  = '0;
                        fill_next = '0;
                        ptr_next  = '0;
                    end
                    out_valid_next                = 1'b1;
                    out_item_next.helmet_state    = mode_f;
                    out_item_next.magnitude       = is_sample ? mag_reg : '0;
                    out_item_next.average         = is_sample ? avg_reg : '0;
                    out_item_next.crash_event     = upd_crash_ev;
                    out_item_next.brake_seen      = upd_brake;
                    out_item_next.crash_confirmed = upd_conf;
                    state_next                    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            sum_reg        <= '0;
            fill_reg       <= '0;
            ptr_reg        <= '0;
            mode_reg       <= HS_NORMAL;
            brake_el_reg   <= '0;
            crash_el_reg   <= '0;
            crash_thr_reg  <= CRASH_THR_RST;
            brake_thr_reg  <= BRAKE_THR_RST;
            brake_hold_reg <= BRAKE_HOLD_RST;
            crash_conf_reg <= CRASH_CONF_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            sum_reg        <= sum_next;
            fill_reg       <= fill_next;
            ptr_reg        <= ptr_next;
            mode_reg       <= mode_next;
            brake_el_reg   <= brake_el_next;
            crash_el_reg   <= crash_el_next;
            crash_thr_reg  <= crash_thr_next;
            brake_thr_reg  <= brake_thr_next;
            brake_hold_reg <= brake_hold_next;
            crash_conf_reg <= crash_conf_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        prod_reg     <= prod_next;
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        mag_reg      <= mag_next;
        avg_reg      <= avg_next;
        out_item_reg <= out_item_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            win_mem[ptr_reg] <= root_reg[15:0];
        old_mag_reg <= win_mem[ptr_reg];
    end

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(WINDOW))
        else $error("window fill count beyond window size");

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= PTR_W'(WINDOW - 1))
        else $error("window pointer beyond window size");

    a_crash_ev_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.crash_event |-> out_item_reg.helmet_state == HS_CRASH)
        else $error("crash event without crash alert state");

    a_confirm_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.crash_confirmed
            |-> out_item_reg.helmet_state == HS_CRASH)
        else $error("crash confirmed outside crash alert");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("new item taken while one is in work");
`endif

endmodule
